>>> rtl/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Types and constants of the pixel colour filter: pixel beats, filter
// modes and the sepia matrix in unsigned fixed point.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int CHANNEL_BITS   = 8;
    localparam int COEF_FRAC_BITS = 10;
    localparam int MODE_BITS      = 4;
    localparam int COEF_BITS      = COEF_FRAC_BITS;
    localparam int ACC_BITS       = CHANNEL_BITS + COEF_BITS + 2;

    localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};

    // coefficient per mille, rounded half up to Q0.COEF_FRAC_BITS
    localparam int SCALE = 2 ** COEF_FRAC_BITS;
    localparam logic [COEF_BITS-1:0] K_RR = COEF_BITS'((393 * SCALE + 500) / 1000);
    localparam logic [COEF_BITS-1:0] K_RG = COEF_BITS'((769 * SCALE + 500) / 1000);
    localparam logic [COEF_BITS-1:0] K_RB = COEF_BITS'((189 * SCALE + 500) / 1000);
    localparam logic [COEF_BITS-1:0] K_GR = COEF_BITS'((349 * SCALE + 500) / 1000);
    localparam logic [COEF_BITS-1:0] K_GG = COEF_BITS'((686 * SCALE + 500) / 1000);
    localparam logic [COEF_BITS-1:0] K_GB = COEF_BITS'((168 * SCALE + 500) / 1000);
    localparam logic [COEF_BITS-1:0] K_BR = COEF_BITS'((272 * SCALE + 500) / 1000);
    localparam logic [COEF_BITS-1:0] K_BG = COEF_BITS'((534 * SCALE + 500) / 1000);
    localparam logic [COEF_BITS-1:0] K_BB = COEF_BITS'((131 * SCALE + 500) / 1000);

    localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_NONE     = 4'd0,
        MODE_SEPIA    = 4'd1,
        MODE_RED      = 4'd2,
        MODE_GREEN    = 4'd3,
        MODE_BLUE     = 4'd4,
        MODE_GRAY_R   = 4'd5,
        MODE_GRAY_G   = 4'd6,
        MODE_GRAY_B   = 4'd7,
        MODE_GRAY_MIN = 4'd8,
        MODE_GRAY_MAX = 4'd9,
        MODE_NEGATIVE = 4'd10
    } t_mode;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
    } t_pixel_in;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
    } t_pixel_out;

endpackage

>>> rtl/pixel_color_filter_unit.sv
// ----------------------------------------------------------------------------
// pixel_color_filter_unit
// Per-pixel colour filter: sepia matrix, single-channel, grey and negative
// modes selected by one configuration register.
// ----------------------------------------------------------------------------
// the result strobe rises once the pixel has passed the input register and the result register
// throughput: one pixel per cycle, busy is never raised
// the filter runs between an input register and a result register
// reset (synchronous, active low) clears the valid bits and sets the mode to none
// configuration is always ready and takes effect on the next pixel
module pixel_color_filter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  pcf_pkg::t_pixel_in              i_pixel,
    output logic                            o_res_valid,
    output pcf_pkg::t_pixel_out             o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pcf_pkg::MODE_BITS-1:0]   i_cfg_data
);

    localparam int CB = pcf_pkg::CHANNEL_BITS;
    localparam int AB = pcf_pkg::ACC_BITS;

    logic                      r_in_vld;
    pcf_pkg::t_pixel_in        r_px;
    logic [pcf_pkg::MODE_BITS-1:0] r_mode;
    logic                      r_res_vld;
    pcf_pkg::t_pixel_out       r_res;
    pcf_pkg::t_pixel_out       n_res;

    logic [AB-1:0]             acc_r;
    logic [AB-1:0]             acc_g;
    logic [AB-1:0]             acc_b;
    logic [CB-1:0]             sep_r;
    logic [CB-1:0]             sep_g;
    logic [CB-1:0]             sep_b;
    logic [CB-1:0]             px_min;
    logic [CB-1:0]             px_max;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_res_vld <= 1'b0;
            r_mode    <= pcf_pkg::MODE_NONE;
        end else begin
            r_in_vld  <= start && !busy;
            r_res_vld <= r_in_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_px <= i_pixel;
        end
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    function automatic logic [CB-1:0] sat_round(input logic [AB-1:0] acc);
        logic [AB-1:0] rnd;
        rnd = (acc + pcf_pkg::ROUND_HALF) >> pcf_pkg::COEF_FRAC_BITS;
        return (rnd > AB'(pcf_pkg::CHAN_MAX)) ? pcf_pkg::CHAN_MAX : rnd[CB-1:0];
    endfunction

    always_comb begin
        acc_r = AB'(r_px.red_in) * AB'(pcf_pkg::K_RR)
              + AB'(r_px.green_in) * AB'(pcf_pkg::K_RG)
              + AB'(r_px.blue_in) * AB'(pcf_pkg::K_RB);
        acc_g = AB'(r_px.red_in) * AB'(pcf_pkg::K_GR)
              + AB'(r_px.green_in) * AB'(pcf_pkg::K_GG)
              + AB'(r_px.blue_in) * AB'(pcf_pkg::K_GB);
        acc_b = AB'(r_px.red_in) * AB'(pcf_pkg::K_BR)
              + AB'(r_px.green_in) * AB'(pcf_pkg::K_BG)
              + AB'(r_px.blue_in) * AB'(pcf_pkg::K_BB);
        sep_r = sat_round(acc_r);
        sep_g = sat_round(acc_g);
        sep_b = sat_round(acc_b);

        px_min = r_px.red_in;
        px_max = r_px.red_in;
        if (r_px.green_in < px_min) px_min = r_px.green_in;
        if (r_px.blue_in  < px_min) px_min = r_px.blue_in;
        if (r_px.green_in > px_max) px_max = r_px.green_in;
        if (r_px.blue_in  > px_max) px_max = r_px.blue_in;
    end

    always_comb begin
        n_res = '{red_out: r_px.red_in, green_out: r_px.green_in, blue_out: r_px.blue_in};
        unique case (r_mode)
            pcf_pkg::MODE_SEPIA: begin
                n_res = '{red_out: sep_r, green_out: sep_g, blue_out: sep_b};
            end
            pcf_pkg::MODE_RED: begin
                n_res = '{red_out: r_px.red_in, green_out: '0, blue_out: '0};
            end
            pcf_pkg::MODE_GREEN: begin
                n_res = '{red_out: '0, green_out: r_px.green_in, blue_out: '0};
            end
            pcf_pkg::MODE_BLUE: begin
                n_res = '{red_out: '0, green_out: '0, blue_out: r_px.blue_in};
            end
            pcf_pkg::MODE_GRAY_R: begin
                n_res = '{red_out: r_px.red_in, green_out: r_px.red_in,
                          blue_out: r_px.red_in};
            end
            pcf_pkg::MODE_GRAY_G: begin
                n_res = '{red_out: r_px.green_in, green_out: r_px.green_in,
                          blue_out: r_px.green_in};
            end
            pcf_pkg::MODE_GRAY_B: begin
                n_res = '{red_out: r_px.blue_in, green_out: r_px.blue_in,
                          blue_out: r_px.blue_in};
            end
            pcf_pkg::MODE_GRAY_MIN: begin
                n_res = '{red_out: px_min, green_out: px_min, blue_out: px_min};
            end
            pcf_pkg::MODE_GRAY_MAX: begin
                n_res = '{red_out: px_max, green_out: px_max, blue_out: px_max};
            end
            pcf_pkg::MODE_NEGATIVE: begin
                n_res = '{red_out: pcf_pkg::CHAN_MAX - r_px.red_in,
                          green_out: pcf_pkg::CHAN_MAX - r_px.green_in,
                          blue_out: pcf_pkg::CHAN_MAX - r_px.blue_in};
            end
            default: begin
                // no filter and unused codes pass the pixel through
                n_res = '{red_out: r_px.red_in, green_out: r_px.green_in,
                          blue_out: r_px.blue_in};
            end
        endcase
    end

    assign o_res_valid = r_res_vld;
    assign o_result    = r_res;

endmodule

>>> rtl/pcf_checker.sv
// ----------------------------------------------------------------------------
// pcf_checker
// Port-level checks of the pixel colour filter, bound to the top level.
// ----------------------------------------------------------------------------
module pcf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input pcf_pkg::t_pixel_in              i_pixel,
    input logic                            o_res_valid,
    input pcf_pkg::t_pixel_out             o_result,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [pcf_pkg::MODE_BITS-1:0]   i_cfg_data
);

    logic cfg_wr;
    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    // every accepted beat gives its result once it has passed the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_res_valid)
        else $error("accepted beat without result");

    // no result without a matching accepted beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(start && !busy, 2))
        else $error("result strobe without accepted beat");

    // the block never stalls either channel
    a_never_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("busy or config not ready");

    // stateless: same pixel under the same mode gives the same result
    a_stateless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && $past(o_res_valid)
            && ($past(i_pixel, 2) == $past(i_pixel, 3))
            && !$past(cfg_wr, 1) && !$past(cfg_wr, 2) && !$past(cfg_wr, 3)
            |-> o_result == $past(o_result))
        else $error("result depends on history");

endmodule

bind pixel_color_filter_unit pcf_checker u_pcf_checker (.*);
